@@ hw/rtl/lps_pkg.sv @@
// Package for the LED pixel serializer: field widths, register indexes,
// reset values and the structs passed between the lanes and the serializer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

  localparam int unsigned MaxLeds     = 1024;
  localparam int unsigned IdxW        = 10;
  localparam int unsigned ChanW       = 8;
  localparam int unsigned CountW      = 11;
  localparam int unsigned TickW       = 15;
  localparam int unsigned BitTickW    = 8;
  localparam int unsigned NumLanes    = 3;
  localparam int unsigned WordBits    = NumLanes * ChanW;
  localparam int unsigned BitCntW     = $clog2(WordBits + 1);
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 15;
  localparam int unsigned InDataW     = 40;
  localparam int unsigned OutDataW    = 32;

  typedef enum logic [CfgIdxW-1:0] {
    RegBrightness = 3'd0,
    RegLedCount   = 3'd1,
    RegZeroHigh   = 3'd2,
    RegZeroLow    = 3'd3,
    RegOneHigh    = 3'd4,
    RegOneLow     = 3'd5,
    RegLatchHalf  = 3'd6
  } cfg_reg_e;

  localparam logic [ChanW-1:0]    BrightnessRst = 8'd255;
  localparam logic [CountW-1:0]   LedCountRst   = 11'd1024;
  localparam logic [BitTickW-1:0] ZeroHighRst   = 8'd3;
  localparam logic [BitTickW-1:0] ZeroLowRst    = 8'd9;
  localparam logic [BitTickW-1:0] OneHighRst    = 8'd9;
  localparam logic [BitTickW-1:0] OneLowRst     = 8'd3;
  localparam logic [TickW-1:0]    LatchHalfRst  = 15'd1400;
  localparam logic [CountW-1:0]   MaxLedsVal    = CountW'(MaxLeds);

  // Symbol timing handed to the serializer.
  typedef struct packed {
    logic [BitTickW-1:0] zero_high;
    logic [BitTickW-1:0] zero_low;
    logic [BitTickW-1:0] one_high;
    logic [BitTickW-1:0] one_low;
    logic [TickW-1:0]    latch_half;
  } sym_cfg_t;

  // One merged pixel waiting for the serializer.
  typedef struct packed {
    logic                keep;
    logic                frame_end;
    logic [WordBits-1:0] word;   // G in the top byte, then R, then B
  } pix_word_t;

  // One output symbol.
  typedef struct packed {
    logic [TickW-1:0] first_ticks;
    logic [TickW-1:0] second_ticks;
    logic             first_level;
    logic             is_latch;
    logic             run_last;
  } symbol_t;

endpackage

`default_nettype wire

@@ hw/rtl/lps_scale_lane.sv @@
// One brightness scaling lane: registers (v * (brightness + 1)) >> 8.
// Depends on lps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lps_scale_lane (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [lps_pkg::ChanW-1:0] chan_i,
  input  wire logic [lps_pkg::ChanW-1:0] brightness_i,
  output logic      [lps_pkg::ChanW-1:0] chan_o
);
  import lps_pkg::*;

  logic [ChanW:0]     factor;
  logic [2*ChanW:0]   prod;
  logic [ChanW-1:0]   chan_d, chan_q;

  assign factor = {1'b0, brightness_i} + (ChanW+1)'(1);
  assign prod   = {{(ChanW+1){1'b0}}, chan_i} * {{ChanW{1'b0}}, factor};
  // product never exceeds 255*256, so bits [15:8] hold the whole result
  assign chan_d = prod[2*ChanW-1:ChanW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

`default_nettype wire

@@ hw/rtl/lps_serializer.sv @@
// Merge stage to symbol stream: shifts a 24-bit GRB word out MSB first,
// one symbol a cycle if not stalled, then any latch. Depends on lps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lps_serializer (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lps_pkg::sym_cfg_t   cfg_i,
  input  wire logic                ld_valid_i,
  input  wire lps_pkg::pix_word_t  ld_item_i,
  output logic                     ld_ready_o,
  output logic                     sym_valid_o,
  output lps_pkg::symbol_t         sym_o,
  input  wire logic                sym_ready_i
);
  import lps_pkg::*;

  logic [BitCntW-1:0]  bits_left_d, bits_left_q;
  logic [WordBits-1:0] word_d, word_q;
  logic                latch_d, latch_q;
  logic                out_valid_d, out_valid_q;
  symbol_t             out_d, out_q;
  logic                busy, out_free, emit, final_sym, load, data_sym, bit_one;

  assign busy      = (bits_left_q != '0) || latch_q;
  assign out_free  = !out_valid_q || sym_ready_i;
  assign emit      = busy && out_free;
  assign data_sym  = (bits_left_q != '0);
  assign final_sym = emit && ((bits_left_q == BitCntW'(1) && !latch_q) ||
                              (!data_sym && latch_q));
  assign load      = ld_valid_i && (!busy || final_sym);
  assign ld_ready_o = !busy || final_sym;
  assign bit_one   = word_q[WordBits-1];

  always_comb begin
    bits_left_d = bits_left_q;
    word_d      = word_q;
    latch_d     = latch_q;
    if (load) begin
      bits_left_d = ld_item_i.keep ? BitCntW'(WordBits) : '0;
      word_d      = ld_item_i.word;
      latch_d     = ld_item_i.frame_end;
    end else if (emit) begin
      if (data_sym) begin
        bits_left_d = bits_left_q - BitCntW'(1);
        word_d      = {word_q[WordBits-2:0], 1'b0};
      end else begin
        latch_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_d = out_q;
    if (data_sym) begin
      out_d.first_ticks  = TickW'(bit_one ? cfg_i.one_high : cfg_i.zero_high);
      out_d.second_ticks = TickW'(bit_one ? cfg_i.one_low : cfg_i.zero_low);
      out_d.first_level  = 1'b1;
      out_d.is_latch     = 1'b0;
    end else begin
      out_d.first_ticks  = cfg_i.latch_half;
      out_d.second_ticks = cfg_i.latch_half;
      out_d.first_level  = 1'b0;
      out_d.is_latch     = 1'b1;
    end
    out_d.run_last = final_sym;
    out_valid_d = emit ? 1'b1 : (sym_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_left_q <= '0;
      latch_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bits_left_q <= bits_left_d;
      latch_q     <= latch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign sym_valid_o = out_valid_q;
  assign sym_o       = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/led_pixel_serializer_core.sv @@
// LED pixel serializer top: config registers, three scaling lanes, merge
// register and the symbol serializer. Depends on lps_pkg, lps_scale_lane,
// lps_serializer.
// Path: lane and merge registers, serializer shift register, output register.
// A kept pixel gives 24 symbols, 25 with the latch; a dropped one without frame
// end gives none. The serializer emits one symbol per cycle unless stalled.
// Reset: async active low; registers return to defaults, pipeline empties.
`timescale 1ns / 1ps
`default_nettype none

module led_pixel_serializer_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // pixel input
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: [9:0] pixel_index, [17:10] red, [25:18] green, [33:26] blue, rest 0
  input  wire logic [lps_pkg::InDataW-1:0]   s_axis_tdata,
  input  wire logic                          s_axis_tlast,   // frame_end
  // symbol output
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: [14:0] first_ticks, [29:15] second_ticks, [30] first_level, [31] 0
  output logic      [lps_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                               m_axis_tuser,   // is_latch
  output logic                               m_axis_tlast,   // run_last
  // config write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lps_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [lps_pkg::CfgDataW-1:0]  cfg_data_i
);
  import lps_pkg::*;

  // ---- config registers ----
  logic [ChanW-1:0]    brightness_q;
  logic [CountW-1:0]   led_count_q;
  sym_cfg_t            sym_cfg_q;
  logic                cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q         <= BrightnessRst;
      led_count_q          <= LedCountRst;
      sym_cfg_q.zero_high  <= ZeroHighRst;
      sym_cfg_q.zero_low   <= ZeroLowRst;
      sym_cfg_q.one_high   <= OneHighRst;
      sym_cfg_q.one_low    <= OneLowRst;
      sym_cfg_q.latch_half <= LatchHalfRst;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index_i))
        RegBrightness: brightness_q         <= cfg_data_i[ChanW-1:0];
        RegLedCount:   led_count_q          <= cfg_data_i[CountW-1:0];
        RegZeroHigh:   sym_cfg_q.zero_high  <= cfg_data_i[BitTickW-1:0];
        RegZeroLow:    sym_cfg_q.zero_low   <= cfg_data_i[BitTickW-1:0];
        RegOneHigh:    sym_cfg_q.one_high   <= cfg_data_i[BitTickW-1:0];
        RegOneLow:     sym_cfg_q.one_low    <= cfg_data_i[BitTickW-1:0];
        RegLatchHalf:  sym_cfg_q.latch_half <= cfg_data_i[TickW-1:0];
        default: ;     // unused index, write dropped
      endcase
    end
  end

  // ---- input unpack ----
  logic [IdxW-1:0]  pix_idx;
  logic [ChanW-1:0] chan_in [NumLanes];
  logic [ChanW-1:0] chan_sc [NumLanes];
  logic [CountW-1:0] limit;
  logic             in_acc, keep_in;

  assign pix_idx    = s_axis_tdata[IdxW-1:0];
  // lane order matches transmit order: green, red, blue
  assign chan_in[0] = s_axis_tdata[IdxW+2*ChanW-1 -: ChanW];
  assign chan_in[1] = s_axis_tdata[IdxW+ChanW-1   -: ChanW];
  assign chan_in[2] = s_axis_tdata[IdxW+3*ChanW-1 -: ChanW];

  // LED count above the strip maximum is clamped
  assign limit   = (led_count_q > MaxLedsVal) ? MaxLedsVal : led_count_q;
  assign keep_in = ({{(CountW-IdxW){1'b0}}, pix_idx} < limit);
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  // ---- lanes ----
  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    lps_scale_lane u_lane (
      .clk_i        (clk_i),
      .en_i         (in_acc),
      .chan_i       (chan_in[l]),
      .brightness_i (brightness_q),
      .chan_o       (chan_sc[l])
    );
  end

  // ---- merge stage: side info held beside the lane registers ----
  logic      st_valid_q, st_keep_q, st_fe_q;
  logic      ld_ready;
  pix_word_t merged;

  assign s_axis_tready = !st_valid_q || ld_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      st_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      st_keep_q <= keep_in;
      st_fe_q   <= s_axis_tlast;
    end
  end

  assign merged.keep      = st_keep_q;
  assign merged.frame_end = st_fe_q;
  assign merged.word      = {chan_sc[0], chan_sc[1], chan_sc[2]};

  // ---- serializer with output register ----
  symbol_t sym;

  lps_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (sym_cfg_q),
    .ld_valid_i  (st_valid_q),
    .ld_item_i   (merged),
    .ld_ready_o  (ld_ready),
    .sym_valid_o (m_axis_tvalid),
    .sym_o       (sym),
    .sym_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, sym.first_level, sym.second_ticks, sym.first_ticks};
  assign m_axis_tuser = sym.is_latch;
  assign m_axis_tlast = sym.run_last;

endmodule

`default_nettype wire

@@ tb/sv/tb_led_pixel_serializer_core.sv @@
// Self-checking testbench for led_pixel_serializer_core: pixels go in, one symbol
// word per data bit (and a latch word on frame end) comes out; a built-in encoder
// model predicts every word. Depends on lps_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_led_pixel_serializer_core;
  import lps_pkg::*;

  localparam int unsigned          SettleCycles = 8;
  localparam int unsigned          QuietLimit   = 2000;  // cycles with no word moving
  localparam int unsigned          MaxShown     = 10;
  localparam logic [CfgIdxW-1:0]   RegNone      = 3'd7;  // unmapped, writes dropped

  typedef struct packed {
    logic [IdxW-1:0]  index;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             frame_end;
  } pixel_t;

  typedef struct {
    logic [ChanW-1:0]    brightness;
    logic [CountW-1:0]   led_count;
    logic [BitTickW-1:0] zero_high;
    logic [BitTickW-1:0] zero_low;
    logic [BitTickW-1:0] one_high;
    logic [BitTickW-1:0] one_low;
    logic [TickW-1:0]    latch_half;
  } strip_regs_t;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                px_valid  = 1'b0;
  logic                px_ready;
  logic [InDataW-1:0]  px_data   = '0;
  logic                px_last   = 1'b0;
  logic                sym_valid;
  logic                sym_ready = 1'b0;
  logic [OutDataW-1:0] sym_data;
  logic                sym_user;
  logic                sym_last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  strip_regs_t regs = '{BrightnessRst, LedCountRst, ZeroHighRst, ZeroLowRst,
                        OneHighRst, OneLowRst, LatchHalfRst};

  pixel_t      pixel_q[$];
  symbol_t     symbol_q[$];
  pixel_t      px_cur;
  int unsigned pixels_queued  = 0;
  int unsigned pixels_taken   = 0;
  int unsigned symbols_seen   = 0;
  int unsigned fail_count     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  led_pixel_serializer_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (px_valid),
    .s_axis_tready (px_ready),
    .s_axis_tdata  (px_data),
    .s_axis_tlast  (px_last),
    .m_axis_tvalid (sym_valid),
    .m_axis_tready (sym_ready),
    .m_axis_tdata  (sym_data),
    .m_axis_tuser  (sym_user),
    .m_axis_tlast  (sym_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- encoder model
  function automatic logic [ChanW-1:0] scale_chan(logic [ChanW-1:0] v);
    logic [16:0] prod;
    prod = 17'(v) * (17'(regs.brightness) + 17'd1);
    return prod[15:8];
  endfunction

  function automatic void encode_pixel(pixel_t p);
    logic [CountW-1:0]   lim;
    logic [WordBits-1:0] grb;
    symbol_t             s;
    lim = (regs.led_count > MaxLedsVal) ? MaxLedsVal : regs.led_count;
    if (CountW'(p.index) < lim) begin
      grb = {scale_chan(p.green), scale_chan(p.red), scale_chan(p.blue)};
      for (int i = WordBits - 1; i >= 0; i--) begin
        s.first_level = 1'b1;
        s.is_latch    = 1'b0;
        s.run_last    = !p.frame_end && (i == 0);
        if (grb[i]) begin
          s.first_ticks  = TickW'(regs.one_high);
          s.second_ticks = TickW'(regs.one_low);
        end else begin
          s.first_ticks  = TickW'(regs.zero_high);
          s.second_ticks = TickW'(regs.zero_low);
        end
        symbol_q.push_back(s);
      end
    end
    if (p.frame_end) begin
      s = '{regs.latch_half, regs.latch_half, 1'b0, 1'b1, 1'b1};
      symbol_q.push_back(s);
    end
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MaxShown) $display("%s", msg);
  endfunction

  // ---------------------------------------------------------------- pixel driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      px_valid <= 1'b0;
    end else begin
      if (px_valid && px_ready) begin
        encode_pixel(px_cur);
        pixels_taken++;
      end
      if (!px_valid || px_ready) begin
        if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          px_cur = pixel_q.pop_front();
          px_valid <= 1'b1;
          px_data  <= InDataW'({px_cur.blue, px_cur.green, px_cur.red, px_cur.index});
          px_last  <= px_cur.frame_end;
        end else begin
          px_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- symbol monitor
  always @(posedge clk_i) begin
    symbol_t got;
    symbol_t want;
    if (rst_ni) begin
      sym_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (sym_valid && sym_ready) begin
        got = '{sym_data[14:0], sym_data[29:15], sym_data[30], sym_user, sym_last};
        if (symbol_q.size() == 0) begin
          note_failure($sformatf("symbol %0d: unexpected word, got first %0d second %0d",
                                 symbols_seen, got.first_ticks, got.second_ticks));
        end else begin
          want = symbol_q.pop_front();
          if (got !== want)
            note_failure($sformatf({"symbol %0d: expected first %0d second %0d lvl %b ",
                                    "latch %b last %b, got first %0d second %0d lvl %b ",
                                    "latch %b last %b"}, symbols_seen,
                                   want.first_ticks, want.second_ticks, want.first_level,
                                   want.is_latch, want.run_last, got.first_ticks,
                                   got.second_ticks, got.first_level, got.is_latch,
                                   got.run_last));
        end
        symbols_seen++;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((px_valid && px_ready) || (sym_valid && sym_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("tb_led_pixel_serializer_core: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      RegBrightness: regs.brightness = value[ChanW-1:0];
      RegLedCount:   regs.led_count  = value[CountW-1:0];
      RegZeroHigh:   regs.zero_high  = value[BitTickW-1:0];
      RegZeroLow:    regs.zero_low   = value[BitTickW-1:0];
      RegOneHigh:    regs.one_high   = value[BitTickW-1:0];
      RegOneLow:     regs.one_low    = value[BitTickW-1:0];
      RegLatchHalf:  regs.latch_half = value[TickW-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic add_pixel(int unsigned idx, int unsigned r, int unsigned g, int unsigned b,
                           bit fe);
    pixel_q.push_back('{IdxW'(idx), ChanW'(r), ChanW'(g), ChanW'(b), fe});
    pixels_queued++;
  endtask

  // wait until the core has drained; dropped pixels leave no word behind, so pad
  task automatic settle();
    while (pixels_taken != pixels_queued || symbol_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic int unsigned rand_chan();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // extremes, out-of-range junk in unused upper bits, or a plain value
  function automatic logic [CfgDataW-1:0] pick_reg_value(int unsigned hi);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CfgDataW'(hi);
      2:       return CfgDataW'(1);
      3:       return CfgDataW'($urandom_range(0, 32767));
      default: return CfgDataW'($urandom_range(1, hi));
    endcase
  endfunction

  task automatic randomize_regs();
    write_reg(RegBrightness, pick_reg_value(255));
    if ($urandom_range(0, 3) == 0) write_reg(RegLedCount, pick_reg_value(2047));
    else write_reg(RegLedCount, CfgDataW'($urandom_range(1, 1024)));
    write_reg(RegZeroHigh, pick_reg_value(255));
    write_reg(RegZeroLow, pick_reg_value(255));
    write_reg(RegOneHigh, pick_reg_value(255));
    write_reg(RegOneLow, pick_reg_value(255));
    write_reg(RegLatchHalf, pick_reg_value(32767));
    write_reg(RegNone, CfgDataW'($urandom_range(0, 32767)));
  endtask

  // mostly in-range pixels, some at any index
  task automatic add_random_pixels(int unsigned n);
    logic [CountW-1:0] lim;
    logic [IdxW-1:0]   idx;
    bit                fe;
    lim = (regs.led_count > MaxLedsVal) ? MaxLedsVal : regs.led_count;
    for (int unsigned k = 0; k < n; k++) begin
      fe = ($urandom_range(0, 7) == 0);
      if (lim != 0 && $urandom_range(0, 9) != 0) idx = IdxW'($urandom_range(0, lim - 1));
      else idx = IdxW'($urandom_range(0, 1023));
      add_pixel(idx, rand_chan(), rand_chan(), rand_chan(), fe);
    end
  endtask

  // ---------------------------------------------------------------- test sequence
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset timing, full brightness, top index kept
    add_pixel(0, 0, 0, 0, 0);
    add_pixel(1023, 255, 255, 255, 1);
    add_pixel(5, 8'hAA, 8'h55, 8'h0F, 0);
    add_pixel(7, 8'h01, 8'h80, 8'hF0, 1);
    add_pixel(1023, 8'h5A, 8'hC3, 8'h3C, 1);
    settle();

    // short strip, zero-tick phases, max latch, write to the unmapped index
    write_reg(RegBrightness, 15'd127);
    write_reg(RegLedCount, 15'd4);
    write_reg(RegZeroHigh, 15'd0);
    write_reg(RegZeroLow, 15'd255);
    write_reg(RegOneHigh, 15'd255);
    write_reg(RegOneLow, 15'd0);
    write_reg(RegLatchHalf, 15'd32767);
    write_reg(RegNone, 15'h7FFF);
    add_pixel(3, 255, 255, 255, 0);
    add_pixel(3, 8'hFE, 8'h02, 8'h80, 1);
    add_pixel(4, 255, 255, 255, 0);
    add_pixel(4, 255, 255, 255, 1);
    add_pixel(1023, 8'h81, 8'h7E, 8'h33, 1);
    add_pixel(0, 8'hC0, 8'h03, 8'h18, 0);
    settle();

    // LED count of zero via masked write: only latch words survive
    write_reg(RegBrightness, 15'h7F00);
    write_reg(RegLedCount, 15'h7800);
    write_reg(RegLatchHalf, 15'd0);
    add_pixel(0, 255, 255, 255, 0);
    add_pixel(0, 255, 255, 255, 1);
    add_pixel(512, 8'h12, 8'h34, 8'h56, 1);
    settle();

    // count above the strip limit, low brightness
    write_reg(RegBrightness, 15'd1);
    write_reg(RegLedCount, 15'h7FFF);
    write_reg(RegZeroHigh, 15'd1);
    write_reg(RegZeroLow, 15'd1);
    write_reg(RegOneHigh, 15'd1);
    write_reg(RegOneLow, 15'd255);
    write_reg(RegLatchHalf, 15'd1);
    add_pixel(1023, 255, 128, 127, 1);
    add_pixel(0, 255, 255, 0, 0);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      randomize_regs();
      add_random_pixels(38);
      settle();
    end

    if (symbol_q.size() != 0) note_failure("symbols still expected at end of run");
    if (fail_count == 0) $display("tb_led_pixel_serializer_core: PASS");
    else $display("tb_led_pixel_serializer_core: FAIL");
    $finish;
  end

endmodule
